// ----- sv/bced_pkg.sv -----
// ----------------------------------------------------------------------------
// bced_pkg: shared types and constants of the cross erode/dilate block
// Controller states, command and status groups between controller and
// datapath, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bced_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_C,
    S_RD_R,
    S_CALC,
    S_FL_RD,
    S_FL_OUT
  } bced_state_t;

  typedef struct packed {
    logic cap_in;
    logic rd_c;
    logic rd_r;
    logic calc;
    logic flush_rd;
    logic flush_out;
  } bced_cmd_t;

  typedef struct packed {
    logic k_last;
    logic r_zero;
    logic r_last;
    logic j_last;
    logic out_free;
  } bced_sts_t;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic        MODE_RST   = 1'b0;
  localparam logic [5:0]  WIDTH_RST  = 6'd32;
  localparam logic [12:0] HEIGHT_RST = 13'd1024;

endpackage

// ----- sv/binary_cross_erode_dilate.sv -----
// ----------------------------------------------------------------------------
// binary_cross_erode_dilate: streamed 3x3 cross erosion and dilation
// Binary image in raster order, one word of pixels per request.
// ----------------------------------------------------------------------------
// Source words enter on the in_ stream and result words leave on the out_
// stream, one row behind the source. Each word is a run of LANES pixels,
// bit 0 leftmost, 1 white. mode, width_words and height_rows are set over
// the cfg_ APB port; every register write restarts the frame at row 0.
// An input word passes through four steps: capture, a read of the middle
// and upper row stores, a read of the right-hand neighbour word, and the
// kernel update with the store write. The single read port of the
// middle-row store keeps the two reads apart. A result word is ready in the
// output register in the cycle after the update. The final word of the
// image then walks the last row out of the store, each word read, then
// loaded into the output register, and the final word of the image carries
// out_tlast. A stalled receiver holds the output register and the sequencer
// waits with it. Reset returns the sequencer to idle, empties the output
// register and restarts the frame; store contents need no reset.
// ----------------------------------------------------------------------------
module binary_cross_erode_dilate #(
  parameter int LANES     = 32,
  parameter int MAX_WORDS = 32,
  parameter int MAX_ROWS  = 4096,
  localparam int TDATA_W  = ((LANES + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: pixel_word [LANES-1:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [TDATA_W-1:0]          in_tdata,
  // out_tdata: result_word [LANES-1:0]; out_tlast: image_last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [TDATA_W-1:0]          out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bced_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bced_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bced_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int RW = $clog2(MAX_ROWS);

  bced_pkg::bced_cmd_t cmd;
  bced_pkg::bced_sts_t sts;
  logic                mode;
  logic [AW-1:0]       wm1;
  logic [RW-1:0]       hm1;
  logic                restart;
  logic [LANES-1:0]    out_data;

  bced_regs #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode),
    .wm1         (wm1),
    .hm1         (hm1),
    .restart     (restart)
  );

  bced_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bced_dp #(
    .LANES     (LANES),
    .MAX_WORDS (MAX_WORDS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (mode),
    .wm1        (wm1),
    .hm1        (hm1),
    .restart    (restart),
    .in_data    (in_tdata[LANES-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_data),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_data);

endmodule

// ----- sv/bced_ram.sv -----
// ----------------------------------------------------------------------------
// bced_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while
// no read is requested.
// ----------------------------------------------------------------------------
module bced_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bced_regs.sv -----
// ----------------------------------------------------------------------------
// bced_regs: configuration registers
// APB-style register file for mode, width and height, with the clamped
// last-word and last-row indexes and a frame restart pulse on each write.
// ----------------------------------------------------------------------------
module bced_regs #(
  parameter int MAX_WORDS = 32,
  parameter int MAX_ROWS  = 4096,
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bced_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bced_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bced_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic                       mode,
  output logic [AW-1:0]              wm1,
  output logic [RW-1:0]              hm1,
  output logic                       restart
);

  localparam int WX = ($clog2(MAX_WORDS + 1) > 6) ? $clog2(MAX_WORDS + 1) : 6;
  localparam int HX = ($clog2(MAX_ROWS + 1) > 13) ? $clog2(MAX_ROWS + 1) : 13;

  logic        mode_r;
  logic [5:0]  width_r;
  logic [12:0] height_r;
  logic        wr_en;
  logic [1:0]  idx;
  logic [WX-1:0] w_ext;
  logic [HX-1:0] h_ext;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bced_pkg::MODE_RST;
      width_r  <= bced_pkg::WIDTH_RST;
      height_r <= bced_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        bced_pkg::REG_MODE:   mode_r   <= cfg_pwdata[0];
        bced_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[5:0];
        bced_pkg::REG_HEIGHT: height_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = wr_en && (idx inside {bced_pkg::REG_MODE, bced_pkg::REG_WIDTH,
                                    bced_pkg::REG_HEIGHT});
  end

  always_comb begin
    case (idx)
      bced_pkg::REG_MODE:   cfg_prdata = {{(bced_pkg::CFG_DW - 1){1'b0}}, mode_r};
      bced_pkg::REG_WIDTH:  cfg_prdata = bced_pkg::CFG_DW'(width_r);
      bced_pkg::REG_HEIGHT: cfg_prdata = bced_pkg::CFG_DW'(height_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Zero counts as one; anything above the store depth counts as the maximum.
  always_comb begin
    w_ext = WX'(width_r);
    if (w_ext == '0) begin
      wm1 = '0;
    end else if (w_ext > WX'(MAX_WORDS)) begin
      wm1 = AW'(MAX_WORDS - 1);
    end else begin
      wm1 = AW'(w_ext - WX'(1));
    end
  end

  always_comb begin
    h_ext = HX'(height_r);
    if (h_ext == '0) begin
      hm1 = '0;
    end else if (h_ext > HX'(MAX_ROWS)) begin
      hm1 = RW'(MAX_ROWS - 1);
    end else begin
      hm1 = RW'(h_ext - HX'(1));
    end
  end

  assign mode = mode_r;

endmodule

// ----- sv/bced_ctrl.sv -----
// ----------------------------------------------------------------------------
// bced_ctrl: sequencing state machine
// Steps each input word through the store reads and the result update,
// then walks the last row out at the end of the image.
// ----------------------------------------------------------------------------
module bced_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bced_pkg::bced_sts_t sts,
  output bced_pkg::bced_cmd_t cmd
);

  bced_pkg::bced_state_t state_r;
  bced_pkg::bced_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bced_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      bced_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = bced_pkg::S_RD_C;
        end
      end
      bced_pkg::S_RD_C: begin
        cmd.rd_c  = 1'b1;
        state_nxt = bced_pkg::S_RD_R;
      end
      bced_pkg::S_RD_R: begin
        cmd.rd_r  = 1'b1;
        state_nxt = bced_pkg::S_CALC;
      end
      bced_pkg::S_CALC: begin
        // The first row produces nothing, so it need not wait for the output.
        if (sts.r_zero || sts.out_free) begin
          cmd.calc = 1'b1;
          if (sts.k_last && sts.r_last) begin
            state_nxt = bced_pkg::S_FL_RD;
          end else begin
            state_nxt = bced_pkg::S_IDLE;
          end
        end
      end
      bced_pkg::S_FL_RD: begin
        cmd.flush_rd = 1'b1;
        state_nxt    = bced_pkg::S_FL_OUT;
      end
      bced_pkg::S_FL_OUT: begin
        if (sts.out_free) begin
          cmd.flush_out = 1'b1;
          if (sts.j_last) begin
            state_nxt = bced_pkg::S_IDLE;
          end else begin
            state_nxt = bced_pkg::S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = bced_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/bced_dp.sv -----
// ----------------------------------------------------------------------------
// bced_dp: row stores, counters, cross kernel and output register
// Holds the two row stores, the word and row position, the previous middle
// word and the result register that faces the output channel.
// ----------------------------------------------------------------------------
module bced_dp #(
  parameter int LANES     = 32,
  parameter int MAX_WORDS = 32,
  parameter int MAX_ROWS  = 4096,
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bced_pkg::bced_cmd_t cmd,
  output bced_pkg::bced_sts_t sts,
  input  logic                mode,
  input  logic [AW-1:0]       wm1,
  input  logic [RW-1:0]       hm1,
  input  logic                restart,
  input  logic [LANES-1:0]    in_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [LANES-1:0]    out_data,
  output logic                out_last
);

  logic [AW-1:0]    k_r;
  logic [AW-1:0]    j_r;
  logic [RW-1:0]    r_r;
  logic [LANES-1:0] x_r;
  logic [LANES-1:0] c_r;
  logic [LANES-1:0] u_r;
  logic [LANES-1:0] prev_r;
  logic [LANES-1:0] out_data_r;
  logic             out_valid_r;
  logic             out_last_r;

  logic             k_last;
  logic             out_free;
  logic             mid_re;
  logic [AW-1:0]    mid_raddr;
  logic [LANES-1:0] mid_rdata;
  logic [LANES-1:0] up_rdata;
  logic [LANES-1:0] lw;
  logic [LANES-1:0] rw;
  logic [LANES-1:0] left_tap;
  logic [LANES-1:0] right_tap;
  logic [LANES-1:0] res;
  logic             emit;

  assign k_last   = (k_r == wm1);
  assign out_free = !out_valid_r || out_tready;
  assign emit     = cmd.calc && (r_r != '0);

  assign sts.k_last   = k_last;
  assign sts.r_zero   = (r_r == '0);
  assign sts.r_last   = (r_r == hm1);
  assign sts.j_last   = (j_r == wm1);
  assign sts.out_free = out_free;

  // The middle store is read at the current word, then at its right
  // neighbour, and during the flush at the flush position.
  assign mid_re = cmd.rd_c || (cmd.rd_r && !k_last) || cmd.flush_rd;

  always_comb begin
    if (cmd.rd_r) begin
      mid_raddr = k_r + AW'(1);
    end else if (cmd.flush_rd) begin
      mid_raddr = j_r;
    end else begin
      mid_raddr = k_r;
    end
  end

  bced_ram #(
    .WIDTH (LANES),
    .DEPTH (MAX_WORDS)
  ) u_mid_ram (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (k_r),
    .wdata (x_r),
    .re    (mid_re),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  bced_ram #(
    .WIDTH (LANES),
    .DEPTH (MAX_WORDS)
  ) u_up_ram (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (k_r),
    .wdata (c_r),
    .re    (cmd.rd_c),
    .raddr (k_r),
    .rdata (up_rdata)
  );

  // Bit 0 is the leftmost pixel, so the left neighbour comes from one bit
  // lower and the right neighbour from one bit higher.
  always_comb begin
    lw        = (k_r == '0) ? '0 : prev_r;
    rw        = k_last ? '0 : mid_rdata;
    left_tap  = {c_r[LANES-2:0], lw[LANES-1]};
    right_tap = {rw[0], c_r[LANES-1:1]};
    if (mode) begin
      res = c_r | left_tap | right_tap | u_r | x_r;
    end else begin
      res = c_r & left_tap & right_tap & u_r & x_r;
    end
    if (r_r == RW'(1)) begin
      res = c_r;
    end else begin
      if (k_r == '0) begin
        res[0] = c_r[0];
      end
      if (k_last) begin
        res[LANES-1] = c_r[LANES-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      x_r <= in_data;
    end
    if (cmd.rd_r) begin
      c_r <= mid_rdata;
      u_r <= up_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      k_r    <= '0;
      r_r    <= '0;
      j_r    <= '0;
      prev_r <= '0;
    end else if (cmd.calc) begin
      if (k_last && (r_r == hm1)) begin
        k_r    <= '0;
        r_r    <= '0;
        j_r    <= '0;
        prev_r <= '0;
      end else if (k_last) begin
        k_r    <= '0;
        r_r    <= r_r + RW'(1);
        prev_r <= c_r;
      end else begin
        k_r    <= k_r + AW'(1);
        prev_r <= c_r;
      end
    end else if (cmd.flush_out) begin
      j_r <= j_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit || cmd.flush_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
      out_last_r <= 1'b0;
    end else if (cmd.flush_out) begin
      out_data_r <= mid_rdata;
      out_last_r <= (j_r == wm1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

// ----- sv/bced_checker.sv -----
// ----------------------------------------------------------------------------
// bced_checker: port-level checks of the cross erode/dilate block
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module bced_checker #(
  parameter int LANES = 32,
  localparam int TDATA_W = ((LANES + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast,
  input logic               cfg_pready
);

  // A stalled result must not change under the receiver.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset leaves the block ready for input with nothing to send.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // After a request is taken the stores are read, and no new request is taken meanwhile.
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input taken during store reads");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind binary_cross_erode_dilate bced_checker #(.LANES(LANES)) u_bced_checker (.*);

// ----- sim/binary_cross_erode_dilate_tb.sv -----
// ----------------------------------------------------------------------------
// binary_cross_erode_dilate_tb: self-checking bench for cross erode/dilate
// Streams binary images through the block under a range of register
// settings and receiver/sender pacing. Every result word is compared with
// a line-buffered model of the five-point cross filter kept in the bench.
// ----------------------------------------------------------------------------
module binary_cross_erode_dilate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS   = 32;
  localparam int MAX_ROWS    = 4096;
  localparam int SETTLE      = 12;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } result_t;

  typedef enum logic {ROW_PIXELS, ROW_REGISTER} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] data;
    logic        typed;
    logic [31:0] want_word;
    logic        want_last;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata: pixel_word [31:0]
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: result_word [31:0]; out_tlast: image_last
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [bced_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [bced_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [bced_pkg::CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  binary_cross_erode_dilate dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Filter state as the bench sees it.
  logic [31:0] upper_row [MAX_WORDS];
  logic [31:0] middle_row [MAX_WORDS];
  logic [31:0] prev_middle = '0;
  int unsigned word_idx = 0;
  int unsigned row_idx = 0;
  logic        mode_q = bced_pkg::MODE_RST;
  logic [5:0]  width_q = bced_pkg::WIDTH_RST;
  logic [12:0] height_q = bced_pkg::HEIGHT_RST;

  result_t expected_words[$];
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      words_sent = 0;
  int      words_checked = 0;
  int      registers_written = 0;
  int      mismatch_count = 0;
  int      idle_cycles = 0;

  // Directed requests. The register index is ignored on pixel rows.
  localparam int N_DIRECTED = 32;
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_REGISTER, bced_pkg::REG_WIDTH,  32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_HEIGHT, 32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b1, 32'h00000000, 1'b1},
    '{ROW_REGISTER, bced_pkg::REG_WIDTH,  32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_HEIGHT, 32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hA5A55A5A, 1'b1, 32'hA5A55A5A, 1'b1},
    '{ROW_REGISTER, bced_pkg::REG_HEIGHT, 32'd3,        1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00010000, 1'b1, 32'h00000000, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_MODE,   32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_WIDTH,  32'd2,        1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h80000000, 1'b1, 32'h00000000, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000001, 1'b1, 32'h00000000, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_MODE,   32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_REGISTER, bced_pkg::REG_HEIGHT, 32'd4,        1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'h7FFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_PIXELS,   bced_pkg::REG_MODE,   32'hFFFEFFFF, 1'b0, 32'h0,        1'b0}
  };

  function automatic int unsigned active_width();
    int unsigned w;
    w = {26'd0, width_q};
    if (w < 1) w = 1;
    if (w > MAX_WORDS) w = MAX_WORDS;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = {19'd0, height_q};
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic void restart_frame();
    word_idx = 0;
    row_idx = 0;
    prev_middle = '0;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      bced_pkg::REG_MODE:   mode_q = value[0];
      bced_pkg::REG_WIDTH:  width_q = value[5:0];
      bced_pkg::REG_HEIGHT: height_q = value[12:0];
      default:              return;
    endcase
    restart_frame();
  endfunction

  function automatic logic [31:0] register_value(input logic [1:0] idx);
    case (idx)
      bced_pkg::REG_MODE:   return {31'd0, mode_q};
      bced_pkg::REG_WIDTH:  return {26'd0, width_q};
      bced_pkg::REG_HEIGHT: return {19'd0, height_q};
      default:              return '0;
    endcase
  endfunction

  // Takes one source word, queues the result words it releases and
  // returns how many there were.
  function automatic int cross_filter_word(input logic [31:0] src);
    int unsigned w, h, k, r, j;
    logic [31:0] c, u, lw, rw, left_n, right_n, res;
    int n;
    w = active_width();
    h = active_height();
    k = (word_idx >= w) ? w - 1 : word_idx;
    r = (row_idx >= h) ? h - 1 : row_idx;
    n = 0;
    if (r >= 1) begin
      c = middle_row[k];
      u = upper_row[k];
      lw = (k > 0) ? prev_middle : '0;
      rw = (k + 1 < w) ? middle_row[k + 1] : '0;
      left_n = {c[30:0], lw[31]};
      right_n = {rw[0], c[31:1]};
      res = mode_q ? (c | left_n | right_n | u | src) : (c & left_n & right_n & u & src);
      // The first row and the outer columns are copied through.
      if (r == 1) begin
        res = c;
      end else begin
        if (k == 0) res[0] = c[0];
        if (k == w - 1) res[31] = c[31];
      end
      expected_words.push_back('{res, 1'b0});
      n++;
    end
    prev_middle = middle_row[k];
    upper_row[k] = middle_row[k];
    middle_row[k] = src;
    if (k == w - 1 && r == h - 1) begin
      // The last source word flushes the whole bottom row unchanged.
      for (j = 0; j < w; j++) begin
        expected_words.push_back('{middle_row[j], j == w - 1});
        n++;
      end
      restart_frame();
    end else if (k + 1 >= w) begin
      word_idx = 0;
      row_idx = r + 1;
    end else begin
      word_idx = k + 1;
      row_idx = r;
    end
    return n;
  endfunction

  function automatic logic [31:0] random_pixels();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom & $urandom;
      2:       return $urandom | $urandom;
      default: return $urandom_range(1) ? ~(32'h1 << $urandom_range(31))
                                        : (32'h1 << $urandom_range(31));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s wrong, expected %h, got %h", $time, what, want, got);
  endtask

  task automatic send_word(input logic [31:0] pixels, output int n_results);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pixels;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    n_results = cross_filter_word(pixels);
    words_sent++;
  endtask

  // Lets every outstanding result drain, then gives the block time to finish
  // any request that produced no result.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== register_value(idx)) report_mismatch("register readback", register_value(idx), got);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    drain();
    apb_access(1'b1, idx, value, unused);
    apply_register(idx, value);
    registers_written++;
    check_register(idx);
  endtask

  task automatic set_image(input logic m, input logic [5:0] w, input logic [12:0] h);
    cfg_write(bced_pkg::REG_MODE, {31'd0, m});
    cfg_write(bced_pkg::REG_WIDTH, {26'd0, w});
    cfg_write(bced_pkg::REG_HEIGHT, {19'd0, h});
  endtask

  task automatic run_frame(input int limit);
    int total, i, n;
    total = active_width() * active_height();
    for (i = 0; i < total && i < limit; i++) send_word(random_pixels(), n);
  endtask

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", '0, out_tdata);
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.word) report_mismatch("result word", want.word, out_tdata);
        if (out_tlast !== want.last) report_mismatch("image last flag", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int gap_by_phase [4];
    int stall_by_phase [4];
    stim_row_t step_row;
    int i, p, n, phase_start, frames, total, w_pick;
    logic [5:0] w_rand;
    logic [12:0] h_rand;
    gap_by_phase = '{0, 78, 0, 7};
    stall_by_phase = '{0, 0, 78, 7};
    for (i = 0; i < MAX_WORDS; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    check_register(bced_pkg::REG_MODE);
    check_register(bced_pkg::REG_WIDTH);
    check_register(bced_pkg::REG_HEIGHT);

    // Single-row images, clamped sizes, flat and isolated patterns, and
    // a dilate that has to carry across a word boundary.
    for (i = 0; i < N_DIRECTED; i++) begin
      step_row = directed_rows[i];
      if (step_row.kind == ROW_REGISTER) begin
        cfg_write(step_row.reg_idx, step_row.data);
      end else begin
        send_word(step_row.data, n);
        if (step_row.typed) begin
          repeat (n) void'(expected_words.pop_back());
          expected_words.push_back('{step_row.want_word, step_row.want_last});
        end
      end
    end

    for (p = 0; p < 4; p++) begin
      gap_pct = gap_by_phase[p];
      stall_pct = stall_by_phase[p];
      phase_start = words_sent;
      while (words_sent - phase_start < 8) begin
        w_pick = $urandom_range(9);
        if (w_pick == 0) w_rand = 6'd0;
        else w_rand = 6'($urandom_range(1, 4));
        if ($urandom_range(9) == 0) h_rand = 13'd0;
        else h_rand = 13'($urandom_range(1, 5));
        set_image(1'($urandom_range(1)), w_rand, h_rand);
        frames = $urandom_range(1, 2);
        repeat (frames) begin
          total = active_width() * active_height();
          // Now and then stop part-way so the next register write has to
          // restart a frame in flight.
          if (total > 1 && $urandom_range(4) == 0) run_frame($urandom_range(1, total - 1));
          else run_frame(total);
        end
      end
    end

    // A width above the store depth counts as a full row of 32 words.
    gap_pct = 7;
    stall_pct = 7;
    set_image(1'b1, 6'd63, 13'd1);
    run_frame(MAX_WORDS);
    drain();

    $display("covered %0d source words, %0d result words and %0d register writes",
             words_sent, words_checked, registers_written);
    $display("erode and dilate on images up to 4 words by 5 rows, zero and over-range sizes");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
